// ===== hdl/mrc_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the Modbus RTU response checker.
package mrc_pkg;

  // Largest response frame accepted, in bytes (8 to 256).
  localparam int unsigned MAX_FRAME_BYTES = 16;

  // Width of byte position and stored frame length.
  localparam int unsigned LEN_W = $clog2(MAX_FRAME_BYTES + 1);
  // Width used for the length computed from a byte count (255 + 5).
  localparam int unsigned CNT_W = 9;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  EXC_FLAG = 8'h80;

  localparam logic [LEN_W-1:0] LEN_EXCEPTION = LEN_W'(5);
  localparam logic [LEN_W-1:0] LEN_WRITE     = LEN_W'(8);
  localparam logic [LEN_W-1:0] LEN_CRC       = LEN_W'(2);
  localparam logic [CNT_W-1:0] LEN_READ_OVH  = CNT_W'(5);

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UNIT_ID        = 3'd0,
    CFG_FUNC_CODE      = 3'd1,
    CFG_EXPECTED_COUNT = 3'd2,
    CFG_ECHO_ADDRESS   = 3'd3,
    CFG_ECHO_VALUE     = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_CRC_ERR = 2'd1,
    ST_BAD     = 2'd2,
    ST_EXC     = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]  unit_id;
    logic [6:0]  func_code;
    logic [7:0]  expected_count;
    logic [15:0] echo_address;
    logic [15:0] echo_value;
  } cfg_t;

  typedef struct packed {
    logic       frame_done;
    status_e    status;
    logic [7:0] exception_code;
    logic [7:0] data_byte;
    logic       data_valid;
  } res_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/mrc_if.sv =====
// Valid/ready channel interfaces for received bytes and check results.
interface mrc_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;

  modport source (output valid, output cmd, output rx_byte, input ready);
  modport sink   (input valid, input cmd, input rx_byte, output ready);
endinterface

interface mrc_out_if import mrc_pkg::*;;
  logic       valid;
  logic       ready;
  logic       frame_done;
  status_e    status;
  logic [7:0] exception_code;
  logic [7:0] data_byte;
  logic       data_valid;

  modport source (output valid, output frame_done, output status, output exception_code,
                  output data_byte, output data_valid, input ready);
  modport sink   (input valid, input frame_done, input status, input exception_code,
                  input data_byte, input data_valid, output ready);
endinterface

// ===== hdl/mrc_frame_core.sv =====
// Frame state, length decode, CRC and verdict for one received byte per cycle while acc_i is high.
module mrc_frame_core import mrc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       acc_i,
  input  logic       cmd_i,
  input  logic [7:0] rx_byte_i,
  output res_t       res_o
);

  logic             act_q, act_d;
  logic [LEN_W-1:0] pos_q, pos_d;
  logic [15:0]      crc_q, crc_d;
  logic [LEN_W-1:0] tl_q, tl_d;
  logic             mism_q, mism_d;
  logic [7:0]       exc_q, exc_d;
  logic [7:0]       hb0_q, hb0_d, hb1_q, hb1_d, hb2_q, hb2_d;
  logic [7:0]       crcl_q, crcl_d;

  logic             is_read;
  logic [7:0]       exc_fc;
  logic             act;
  logic [LEN_W-1:0] p;
  logic [LEN_W-1:0] tl;
  logic [15:0]      crc;
  logic [CNT_W-1:0] t_rd;
  logic [7:0]       want;
  logic [15:0]      rx_crc;

  assign is_read = cfg_i.func_code inside {[7'd1:7'd4]};
  assign exc_fc  = EXC_FLAG | {1'b0, cfg_i.func_code};
  assign t_rd    = {1'b0, rx_byte_i} + LEN_READ_OVH;
  assign rx_crc  = {rx_byte_i, crcl_q};

  always_comb begin
    // a new-frame byte restarts from the frame's initial state
    act    = cmd_i | act_q;
    p      = cmd_i ? '0 : pos_q;
    tl     = cmd_i ? '0 : tl_q;
    crc    = cmd_i ? CRC_INIT : crc_q;
    act_d  = act;
    pos_d  = p;
    tl_d   = tl;
    crc_d  = crc;
    mism_d = cmd_i ? 1'b0 : mism_q;
    exc_d  = exc_q;
    hb0_d  = hb0_q;
    hb1_d  = hb1_q;
    hb2_d  = hb2_q;
    crcl_d = crcl_q;
    want   = '0;
    res_o  = '0;

    if (act) begin
      if (p == LEN_W'(0)) hb0_d = rx_byte_i;
      if (p == LEN_W'(1)) hb1_d = rx_byte_i;
      if (p == LEN_W'(2)) hb2_d = rx_byte_i;

      if (p == LEN_W'(1) && !is_read) begin
        tl_d = (rx_byte_i == exc_fc) ? LEN_EXCEPTION : LEN_WRITE;
        if (CNT_W'(tl_d) > CNT_W'(MAX_FRAME_BYTES)) begin
          res_o.frame_done = 1'b1;
          res_o.status     = ST_BAD;
          act_d            = 1'b0;
        end
      end

      if (p == LEN_W'(2) && is_read) begin
        if (hb1_q == exc_fc) begin
          tl_d = LEN_EXCEPTION;
        end else if (rx_byte_i != cfg_i.expected_count ||
                     t_rd > CNT_W'(MAX_FRAME_BYTES)) begin
          res_o.frame_done = 1'b1;
          res_o.status     = ST_BAD;
          act_d            = 1'b0;
        end else begin
          tl_d = t_rd[LEN_W-1:0];
        end
      end

      if (act_d) begin
        // echo check on address and value bytes of a normal write response
        if (!is_read && tl_d == LEN_WRITE && p >= LEN_W'(2) && p <= LEN_W'(5)) begin
          if (p == LEN_W'(2))      want = cfg_i.echo_address[15:8];
          else if (p == LEN_W'(3)) want = cfg_i.echo_address[7:0];
          else if (p == LEN_W'(4)) want = cfg_i.echo_value[15:8];
          else                     want = cfg_i.echo_value[7:0];
          if (rx_byte_i != want) mism_d = 1'b1;
        end

        if (tl_d == '0 || p < tl_d - LEN_CRC) begin
          crc_d = crc16_byte(crc, rx_byte_i);
          if (is_read && tl_d != '0 && p >= LEN_W'(3) && hb1_q != exc_fc) begin
            res_o.data_valid = 1'b1;
            res_o.data_byte  = rx_byte_i;
          end
          pos_d = p + LEN_W'(1);
        end else if (p == tl_d - LEN_CRC) begin
          crcl_d = rx_byte_i;
          pos_d  = p + LEN_W'(1);
        end else begin
          res_o.frame_done = 1'b1;
          if (rx_crc != crc) begin
            res_o.status = ST_CRC_ERR;
          end else if (hb0_q != cfg_i.unit_id) begin
            res_o.status = ST_BAD;
          end else if (hb1_q == exc_fc) begin
            exc_d        = hb2_q;
            res_o.status = ST_EXC;
          end else if (hb1_q != {1'b0, cfg_i.func_code}) begin
            res_o.status = ST_BAD;
          end else begin
            exc_d = '0;
            if (!is_read && (tl_d != LEN_WRITE || mism_d)) res_o.status = ST_BAD;
          end
          act_d = 1'b0;
        end
      end
    end

    res_o.exception_code = exc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= 1'b0;
      pos_q  <= '0;
      crc_q  <= CRC_INIT;
      tl_q   <= '0;
      mism_q <= 1'b0;
      exc_q  <= '0;
    end else if (acc_i) begin
      act_q  <= act_d;
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      tl_q   <= tl_d;
      mism_q <= mism_d;
      exc_q  <= exc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      hb0_q  <= hb0_d;
      hb1_q  <= hb1_d;
      hb2_q  <= hb2_d;
      crcl_q <= crcl_d;
    end
  end

endmodule

// ===== hdl/modbus_rtu_response_checker.sv =====
// Modbus RTU response checker: one received byte per item in, one result per item out.
//
// Feed the response bytes one per item, cmd high on the first byte of a frame. Every
// item yields exactly one result, so a byte a cycle is sustained unless results stall:
// the whole byte step (CRC-16 update, length decode, header and echo compares) sits
// between the input handshake and the result register. A two-entry output buffer (result
// register plus skid register) lets input keep flowing for one item while the result side
// stalls. The frame length comes from the header: read functions 1 to 4 use the byte
// count plus 5 (checked against expected_count and the frame capacity), write functions
// use 8, exception responses 5. Payload bytes of a read response come out with data_valid
// as they arrive; frame_done marks the item that carries the verdict (ok, crc error, bad
// response, exception). exception_code holds the last exception code seen and clears
// after a frame whose CRC, unit and function match. A cmd-0 byte outside a frame gives an
// empty result. Write configuration only while no item is in flight.
module modbus_rtu_response_checker import mrc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  mrc_in_if.sink                rx_i,
  mrc_out_if.source             res_o
);

  cfg_t cfg_q;
  res_t core_res;
  res_t out_q, out_d, skid_q, skid_d;
  logic out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;
  logic acc;
  logic out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unit_id        <= 8'd1;
      cfg_q.func_code      <= 7'd3;
      cfg_q.expected_count <= 8'd2;
      cfg_q.echo_address   <= '0;
      cfg_q.echo_value     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_UNIT_ID:        cfg_q.unit_id        <= cfg_data_i[7:0];
        CFG_FUNC_CODE:      cfg_q.func_code      <= cfg_data_i[6:0];
        CFG_EXPECTED_COUNT: cfg_q.expected_count <= cfg_data_i[7:0];
        CFG_ECHO_ADDRESS:   cfg_q.echo_address   <= cfg_data_i;
        CFG_ECHO_VALUE:     cfg_q.echo_value     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input is taken whenever the skid slot is empty
  assign rx_i.ready = ~skid_vld_q;
  assign acc        = rx_i.valid & rx_i.ready;

  mrc_frame_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .acc_i     (acc),
    .cmd_i     (rx_i.cmd),
    .rx_byte_i (rx_i.rx_byte),
    .res_o     (core_res)
  );

  // result register with skid slot behind it
  assign out_free = ~out_vld_q | res_o.ready;

  always_comb begin
    out_d      = out_q;
    out_vld_d  = out_vld_q;
    skid_d     = skid_q;
    skid_vld_d = skid_vld_q;
    if (out_free) begin
      if (skid_vld_q) begin
        out_d      = skid_q;
        out_vld_d  = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_d     = core_res;
        out_vld_d = acc;
      end
    end else if (acc) begin
      skid_d     = core_res;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.frame_done     = out_q.frame_done;
  assign res_o.status         = out_q.status;
  assign res_o.exception_code = out_q.exception_code;
  assign res_o.data_byte      = out_q.data_byte;
  assign res_o.data_valid     = out_q.data_valid;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the Modbus RTU response checker: directed frames, then random phases.
`timescale 1ns / 100ps

module tb_top;
  import mrc_pkg::*;

  // ---------------------------------------------------------------------------
  // Clock, reset, configuration port and the two item channels
  // ---------------------------------------------------------------------------
  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  mrc_in_if  rx_if ();
  mrc_out_if res_if ();

  always #4 clk_i = ~clk_i;

  modbus_rtu_response_checker u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  // ---------------------------------------------------------------------------
  // Predictor copy of the checker: registers (reset values) and frame state
  // ---------------------------------------------------------------------------
  logic [7:0]       cfg_unit      = 8'd1;
  logic [6:0]       cfg_func      = 7'd3;
  logic [7:0]       cfg_count     = 8'd2;
  logic [15:0]      cfg_echo_addr = 16'h0000;
  logic [15:0]      cfg_echo_val  = 16'h0000;

  logic             rtu_active    = 1'b0;
  logic [LEN_W-1:0] rtu_pos       = '0;
  logic [LEN_W-1:0] rtu_len       = '0;   // 0 while the length is still unknown
  logic [15:0]      rtu_crc       = CRC_INIT;
  logic [7:0]       rtu_hdr [3]   = '{8'h00, 8'h00, 8'h00};
  logic             rtu_echo_bad  = 1'b0;
  logic [7:0]       rtu_crc_lo    = 8'h00;
  logic [7:0]       rtu_exc_code  = 8'h00;

  // Expected results, oldest first; every accepted byte yields exactly one.
  res_t verdict_q [$];
  int   n_bad = 0;

  // Idle-free stretches on either side, redrawn per phase.
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  // Bytes of the frames planned but not yet sent.
  typedef struct packed {
    logic       cmd;
    logic [7:0] b;
  } rx_item_t;
  rx_item_t frame_q [$];

  // ---------------------------------------------------------------------------
  // Directed table. CRC rows take their byte from the predicted running CRC;
  // typed rows carry an expectation read off the spec, the rest use the predictor.
  // ---------------------------------------------------------------------------
  typedef enum logic [1:0] {
    SRC_RAW,
    SRC_CRC_LO,
    SRC_CRC_HI,
    SRC_CRC_BAD
  } byte_src_e;

  typedef struct {
    logic      cmd;
    byte_src_e src;
    logic [7:0] value;
    logic      typed;
    res_t      want;
  } dir_row_t;

  localparam res_t R_NONE    = '{1'b0, ST_OK,      8'h00, 8'h00, 1'b0};
  localparam res_t R_CNT_BAD = '{1'b1, ST_BAD,     8'h00, 8'h00, 1'b0};
  localparam res_t R_EXC_FF  = '{1'b1, ST_EXC,     8'hFF, 8'h00, 1'b0};
  localparam res_t R_CRC_FF  = '{1'b1, ST_CRC_ERR, 8'hFF, 8'h00, 1'b0};

  // Reset config: unit 1, read holding registers (3), byte count 2.
  dir_row_t dir_tab [24] = '{
    // stray byte right after reset: empty result
    '{1'b0, SRC_RAW,     8'hFF, 1'b1, R_NONE},
    // byte count 5 against 2: frame ends at the byte count
    '{1'b1, SRC_RAW,     8'h01, 1'b0, R_NONE},
    '{1'b0, SRC_RAW,     8'h03, 1'b0, R_NONE},
    '{1'b0, SRC_RAW,     8'h05, 1'b1, R_CNT_BAD},
    // one-byte frame dropped by the next start
    '{1'b1, SRC_RAW,     8'h07, 1'b0, R_NONE},
    // good read response, payload 00 FF
    '{1'b1, SRC_RAW,     8'h01, 1'b0, R_NONE},
    '{1'b0, SRC_RAW,     8'h03, 1'b0, R_NONE},
    '{1'b0, SRC_RAW,     8'h02, 1'b0, R_NONE},
    '{1'b0, SRC_RAW,     8'h00, 1'b0, R_NONE},
    '{1'b0, SRC_RAW,     8'hFF, 1'b0, R_NONE},
    '{1'b0, SRC_CRC_LO,  8'h00, 1'b0, R_NONE},
    '{1'b0, SRC_CRC_HI,  8'h00, 1'b0, R_NONE},
    // exception response, code FF is kept
    '{1'b1, SRC_RAW,     8'h01, 1'b0, R_NONE},
    '{1'b0, SRC_RAW,     8'h83, 1'b0, R_NONE},
    '{1'b0, SRC_RAW,     8'hFF, 1'b0, R_NONE},
    '{1'b0, SRC_CRC_LO,  8'h00, 1'b0, R_NONE},
    '{1'b0, SRC_CRC_HI,  8'h00, 1'b1, R_EXC_FF},
    // read response with a corrupted CRC high byte
    '{1'b1, SRC_RAW,     8'h01, 1'b0, R_NONE},
    '{1'b0, SRC_RAW,     8'h03, 1'b0, R_NONE},
    '{1'b0, SRC_RAW,     8'h02, 1'b0, R_NONE},
    '{1'b0, SRC_RAW,     8'hAA, 1'b0, R_NONE},
    '{1'b0, SRC_RAW,     8'h55, 1'b0, R_NONE},
    '{1'b0, SRC_CRC_LO,  8'h00, 1'b0, R_NONE},
    '{1'b0, SRC_CRC_BAD, 8'h00, 1'b1, R_CRC_FF}
  };

  // Reflected CRC-16, one byte, LSB first.
  function automatic logic [15:0] rtu_crc_byte(logic [15:0] acc, logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) begin
      r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
    end
    return r;
  endfunction

  // One byte through the predicted checker; returns the result it causes.
  task automatic rtu_predict(input logic cmd, input logic [7:0] b, output res_t r);
    bit          rd_mode;
    logic [7:0]  exc_fc;
    logic [7:0]  want;
    logic [15:0] got_crc;
    int          p;
    int          t;
    int          len;
    rd_mode = (cfg_func >= 7'd1) && (cfg_func <= 7'd4);
    exc_fc  = {1'b1, cfg_func};
    r = '0;
    r.status = ST_OK;
    if (cmd) begin
      rtu_active   = 1'b1;
      rtu_pos      = '0;
      rtu_crc      = CRC_INIT;
      rtu_len      = '0;
      rtu_echo_bad = 1'b0;
    end
    if (rtu_active) begin
      p = int'(rtu_pos);
      if (p < 3) rtu_hdr[p] = b;
      // write mode: function byte decides exception (5) or echo (8)
      if (p == 1 && !rd_mode) begin
        t = (b == exc_fc) ? 5 : 8;
        if (t > MAX_FRAME_BYTES) begin
          r.frame_done = 1'b1;
          r.status     = ST_BAD;
          rtu_active   = 1'b0;
        end
        rtu_len = LEN_W'(t);
      end
      // read mode: byte count decides, must match and fit
      if (p == 2 && rd_mode) begin
        if (rtu_hdr[1] == exc_fc) t = 5;
        else if (b != cfg_count) t = 0;
        else t = int'(b) + 5;
        if (t == 0 || t > MAX_FRAME_BYTES) begin
          r.frame_done = 1'b1;
          r.status     = ST_BAD;
          rtu_active   = 1'b0;
        end else begin
          rtu_len = LEN_W'(t);
        end
      end
      if (rtu_active) begin
        len = int'(rtu_len);
        if (!rd_mode && len == 8 && p >= 2 && p <= 5) begin
          case (p)
            2:       want = cfg_echo_addr[15:8];
            3:       want = cfg_echo_addr[7:0];
            4:       want = cfg_echo_val[15:8];
            default: want = cfg_echo_val[7:0];
          endcase
          if (b != want) rtu_echo_bad = 1'b1;
        end
        if (len == 0 || p < len - 2) begin
          rtu_crc = rtu_crc_byte(rtu_crc, b);
          if (rd_mode && len != 0 && p >= 3 && rtu_hdr[1] != exc_fc) begin
            r.data_valid = 1'b1;
            r.data_byte  = b;
          end
          rtu_pos = LEN_W'(p + 1);
        end else if (p == len - 2) begin
          rtu_crc_lo = b;
          rtu_pos    = LEN_W'(p + 1);
        end else begin
          // last byte: verdict in priority order
          got_crc = {b, rtu_crc_lo};
          r.frame_done = 1'b1;
          if (got_crc != rtu_crc) begin
            r.status = ST_CRC_ERR;
          end else if (rtu_hdr[0] != cfg_unit) begin
            r.status = ST_BAD;
          end else if (rtu_hdr[1] == exc_fc) begin
            rtu_exc_code = rtu_hdr[2];
            r.status     = ST_EXC;
          end else if (rtu_hdr[1] != {1'b0, cfg_func}) begin
            r.status = ST_BAD;
          end else begin
            rtu_exc_code = 8'h00;
            if (!rd_mode && (len != 8 || rtu_echo_bad)) r.status = ST_BAD;
          end
          rtu_active = 1'b0;
        end
      end
    end
    r.exception_code = rtu_exc_code;
  endtask

  // Byte with a fair share of the extremes.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // Plan one response frame (mostly well formed) or a short burst of noise.
  task automatic plan_frame(input bit noise_ok);
    logic [7:0]  fb [$];
    logic [15:0] c;
    logic [7:0]  cnt;
    bit          rd;
    int          n;
    int          sel;
    int          k;
    int          cut;
    rd = (cfg_func >= 7'd1) && (cfg_func <= 7'd4);
    if (noise_ok && $urandom_range(0, 99) < 8) begin
      n = $urandom_range(1, 4);
      repeat (n) frame_q.push_back('{cmd: ($urandom_range(0, 5) == 0), b: 8'($urandom)});
      return;
    end
    fb.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : cfg_unit);
    sel = $urandom_range(0, 9);
    if (sel == 0) fb.push_back({1'b1, cfg_func});        // exception
    else if (sel == 1) fb.push_back(8'($urandom));       // likely wrong function
    else fb.push_back({1'b0, cfg_func});
    if (sel == 0) begin
      fb.push_back(pick_byte());
    end else if (rd) begin
      cnt = ($urandom_range(0, 7) == 0) ? 8'($urandom) : cfg_count;
      fb.push_back(cnt);
      n = (int'(cnt) > 11) ? 11 : int'(cnt);
      repeat (n) fb.push_back(pick_byte());
    end else begin
      fb.push_back(cfg_echo_addr[15:8]);
      fb.push_back(cfg_echo_addr[7:0]);
      fb.push_back(cfg_echo_val[15:8]);
      fb.push_back(cfg_echo_val[7:0]);
      if ($urandom_range(0, 6) == 0) begin
        k = $urandom_range(2, 5);
        fb[k] = fb[k] ^ (8'h01 << $urandom_range(0, 7));
      end
    end
    c = CRC_INIT;
    foreach (fb[i]) c = rtu_crc_byte(c, fb[i]);
    if ($urandom_range(0, 9) == 0) c = c ^ (16'h0001 << $urandom_range(0, 15));
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    // now and then a truncated frame, dropped by the next start
    if ($urandom_range(0, 12) == 0) begin
      cut = $urandom_range(1, fb.size() - 1);
      while (fb.size() > cut) void'(fb.pop_back());
    end
    foreach (fb[i]) frame_q.push_back('{cmd: (i == 0), b: fb[i]});
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Offer one item after a random gap; predict it once accepted.
  task automatic push_item(input logic cmd, input logic [7:0] b, input logic typed,
                           input res_t want);
    int   gap;
    res_t pr;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.cmd     <= cmd;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (rx_if.ready !== 1'b1);
    rtu_predict(cmd, b, pr);
    verdict_q.push_back(typed ? want : pr);
  endtask

  // Hold off input until every result is back, then add idle slack.
  task automatic wait_idle();
    rx_if.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  // Write all five registers; unused upper data bits carry junk.
  task automatic apply_cfg(input logic [7:0] unit, input logic [6:0] fc, input logic [7:0] cnt,
                           input logic [15:0] ea, input logic [15:0] ev);
    write_reg(CFG_UNIT_ID, {8'($urandom), unit});
    write_reg(CFG_FUNC_CODE, {9'($urandom), fc});
    write_reg(CFG_EXPECTED_COUNT, {8'($urandom), cnt});
    write_reg(CFG_ECHO_ADDRESS, ea);
    write_reg(CFG_ECHO_VALUE, ev);
    cfg_we        <= 1'b0;
    cfg_unit      = unit;
    cfg_func      = fc;
    cfg_count     = cnt;
    cfg_echo_addr = ea;
    cfg_echo_val  = ev;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, each result checked against the oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_verdict();
    res_t w;
    if (verdict_q.size() == 0) begin
      $error("result with nothing expected");
      n_bad++;
    end else begin
      w = verdict_q.pop_front();
      if (res_if.frame_done !== w.frame_done) begin
        $error("frame_done expected %0d actual %0d", w.frame_done, res_if.frame_done);
        n_bad++;
      end
      if (res_if.status !== w.status) begin
        $error("status expected %0d actual %0d", w.status, res_if.status);
        n_bad++;
      end
      if (res_if.exception_code !== w.exception_code) begin
        $error("exception_code expected %0h actual %0h", w.exception_code,
               res_if.exception_code);
        n_bad++;
      end
      if (res_if.data_byte !== w.data_byte) begin
        $error("data_byte expected %0h actual %0h", w.data_byte, res_if.data_byte);
        n_bad++;
      end
      if (res_if.data_valid !== w.data_valid) begin
        $error("data_valid expected %0d actual %0d", w.data_valid, res_if.data_valid);
        n_bad++;
      end
    end
  endtask

  initial begin
    int stall;
    res_if.ready <= 1'b0;
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
      check_verdict();
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence: reset, directed table, then random phases with new settings
  // ---------------------------------------------------------------------------
  initial begin
    logic [7:0] b;
    rx_item_t   nxt;
    int         sent;
    bit         first;
    rst_ni        <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= CFG_UNIT_ID;
    cfg_data      <= '0;
    rx_if.valid   <= 1'b0;
    rx_if.cmd     <= 1'b0;
    rx_if.rx_byte <= 8'h00;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      case (dir_tab[i].src)
        SRC_CRC_LO:  b = rtu_crc[7:0];
        SRC_CRC_HI:  b = rtu_crc[15:8];
        SRC_CRC_BAD: b = rtu_crc[15:8] ^ 8'h01;
        default:     b = dir_tab[i].value;
      endcase
      push_item(dir_tab[i].cmd, b, dir_tab[i].typed, dir_tab[i].want);
    end

    // First phases pin the register extremes, the rest are random.
    for (int ph = 0; ph < 14; ph++) begin
      wait_idle();
      case (ph)
        0: apply_cfg(8'd247, 7'd127, 8'd0, 16'hFFFF, 16'hFFFF);
        1: apply_cfg(8'd1, 7'd0, 8'd255, 16'h0000, 16'h0000);
        2: apply_cfg(8'($urandom_range(1, 247)), 7'd4, 8'd11, 16'($urandom), 16'($urandom));
        3: apply_cfg(8'($urandom_range(1, 247)), 7'd1, 8'd0, 16'($urandom), 16'($urandom));
        default: begin
          apply_cfg(8'($urandom_range(1, 247)),
                    ($urandom_range(0, 1) != 0) ? 7'($urandom_range(1, 4))
                                                : 7'($urandom_range(0, 127)),
                    ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 11)) : 8'($urandom),
                    16'($urandom), 16'($urandom));
        end
      endcase
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      sent  = 0;
      first = 1'b1;
      // a phase opens with a real frame start so no frame spans a register write
      while (sent < 90) begin
        plan_frame(!first);
        first = 1'b0;
        while (frame_q.size() != 0) begin
          nxt = frame_q.pop_front();
          push_item(nxt.cmd, nxt.b, 1'b0, '0);
          sent++;
        end
        if ($urandom_range(0, 24) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (12) @(posedge clk_i);
    if (n_bad == 0 && verdict_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
